@@ design/chfm_pkg.sv @@
// Shared constants, arctangent table and vector type for the compass heading block.
`timescale 1ns / 1ps

package chfm_pkg;

	// Number of micro-rotations; the pipeline gets one stage for each.
	localparam int CORDIC_STEPS = 16;
	localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);

	// Field widths.
	localparam int IW = 16;
	localparam int OW = 16;
	localparam int DW = 16;

	// Vector components are raw counts scaled by 2^PRE_SHIFT.
	localparam int PRE_SHIFT = 14;
	localparam int XW = 34;

	// Angles are in 1/65536 of a hundredth of a degree.
	localparam int FRAC = 16;
	localparam int ZW = 32;
	localparam int HW = 35;
	localparam int RW = HW - FRAC;

	localparam logic signed [ZW-1:0] ANG_90 = 32'sd589824000;
	localparam logic signed [HW-1:0] ANG_360 = 35'sd2359296000;
	localparam logic signed [HW-1:0] ANG_HALF = 35'sd32768;

	localparam logic signed [RW-1:0] HEAD_MAX = 19'sd36000;
	localparam logic [DW-1:0] DECL_RESET = 16'd1891;

	// round(atan(2^-i) * 180/pi * 100 * 65536)
	localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865, 32'sd11730358, 32'sd5866610, 32'sd2933484,
		32'sd1466764, 32'sd733385, 32'sd366693, 32'sd183346,
		32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
		32'sd5730, 32'sd2865, 32'sd1432, 32'sd716,
		32'sd358, 32'sd179, 32'sd90, 32'sd45
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cvec_t;

endpackage

@@ design/chfm_cordic.sv @@
// Vectoring CORDIC pipeline: one micro-rotation per register stage.
`timescale 1ns / 1ps

module chfm_cordic
	import chfm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  cvec_t in_vec,
	output logic  out_valid,
	input  logic  out_ready,
	output cvec_t out_vec
);

	logic  vld_s [NSTEPS];
	logic  rdy   [NSTEPS];
	cvec_t vec_s [NSTEPS];

	genvar k;
	generate
		for (k = 0; k < NSTEPS; k++) begin : g_stage
			logic  prev_valid;
			cvec_t prev_vec;
			cvec_t nxt;
			logic  next_ready;
			logic signed [XW-1:0] dx;
			logic signed [XW-1:0] dy;

			if (k == 0) begin : g_first
				assign prev_valid = in_valid;
				assign prev_vec   = in_vec;
			end else begin : g_mid
				assign prev_valid = vld_s[k-1];
				assign prev_vec   = vec_s[k-1];
			end

			if (k == NSTEPS - 1) begin : g_last
				assign next_ready = out_ready;
			end else begin : g_inner
				assign next_ready = rdy[k+1];
			end

			assign rdy[k] = !vld_s[k] || next_ready;
			assign dx = prev_vec.y >>> k;
			assign dy = prev_vec.x >>> k;

			// Rotate toward the x axis; the sign of y picks the direction.
			always_comb begin
				nxt = prev_vec;
				if (!prev_vec.y[XW-1]) begin
					nxt.x = prev_vec.x + dx;
					nxt.y = prev_vec.y - dy;
					nxt.z = prev_vec.z + ATAN_TAB[k];
				end else begin
					nxt.x = prev_vec.x - dx;
					nxt.y = prev_vec.y + dy;
					nxt.z = prev_vec.z - ATAN_TAB[k];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= prev_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && prev_valid) begin
					vec_s[k] <= nxt;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NSTEPS-1];
	assign out_vec   = vec_s[NSTEPS-1];

endmodule

@@ design/compass_heading_from_magnetometer.sv @@
// Top level: compass heading in hundredths of a degree from one X/Y magnetometer sample.
`timescale 1ns / 1ps

// The block turns one signed X/Y field sample into a heading from 0 to 36000
// hundredths of a degree: the arctangent of mag_y over mag_x, plus the
// declination register, wrapped into one turn and rounded to 0.01 degree.
// A zero vector gives an angle of zero, so the heading is then the wrapped
// declination. The datapath is a fully pipelined chain: one stage folds the
// vector into the right half plane and scales it, one stage per CORDIC
// micro-rotation follows (16 of them), then four stages add the declination,
// wrap low, wrap high with the rounding offset, and clamp into the output
// register, 21 register stages in all. A new sample can be taken in every
// cycle while the output side does not stall. Each stage has its own valid
// bit and ready, so a stalled output fills empty stages before input ready
// drops, and nothing is lost or repeated.
// Declination is written through cfg_we and cfg_wdata, takes effect at once,
// resets to 1891 (0.33 rad), and should only change while no sample is in
// flight.

module compass_heading_from_magnetometer
	import chfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic signed [DW-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [IW-1:0] mag_x,
	input  logic signed [IW-1:0] mag_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic        [OW-1:0] heading
);

	logic signed [DW-1:0] decl_q;

	// Stage 1: quadrant fold and scaling.
	logic                 v_s1;
	cvec_t                vec_s1;
	logic                 rdy1;
	logic signed [IW:0]   mx;
	logic signed [IW:0]   my;
	logic signed [IW:0]   xr;
	logic signed [IW:0]   yr;
	logic signed [ZW-1:0] zr;
	cvec_t                pre;

	// CORDIC handshake.
	logic  cor_in_ready;
	logic  cor_out_valid;
	cvec_t cor_out_vec;

	// Post stages.
	logic                 v_s2;
	logic                 v_s3;
	logic                 v_s4;
	logic                 v_s5;
	logic                 rdy2;
	logic                 rdy3;
	logic                 rdy4;
	logic                 rdy5;
	logic signed [HW-1:0] h_s2;
	logic signed [HW-1:0] h_s3;
	logic signed [HW-1:0] h_s4;
	logic        [OW-1:0] heading_s5;
	logic signed [ZW-1:0] z_eff;
	logic signed [RW-1:0] r_raw;
	logic        [OW-1:0] r_clamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RESET;
		end else if (cfg_we) begin
			decl_q <= cfg_wdata;
		end
	end

	// A vector in the left half plane is turned by a quarter turn into the
	// right half plane, and that quarter turn seeds the angle accumulator.
	always_comb begin
		mx = {mag_x[IW-1], mag_x};
		my = {mag_y[IW-1], mag_y};
		xr = mx;
		yr = my;
		zr = '0;
		if (mx[IW]) begin
			if (!my[IW]) begin
				xr = my;
				yr = -mx;
				zr = ANG_90;
			end else begin
				xr = -my;
				yr = mx;
				zr = -ANG_90;
			end
		end
		pre.x    = XW'(xr) <<< PRE_SHIFT;
		pre.y    = XW'(yr) <<< PRE_SHIFT;
		pre.z    = zr;
		pre.zero = (mag_x == '0) && (mag_y == '0);
	end

	assign rdy1     = !v_s1 || cor_in_ready;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			vec_s1 <= pre;
		end
	end

	chfm_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_in_ready),
		.in_vec    (vec_s1),
		.out_valid (cor_out_valid),
		.out_ready (rdy2),
		.out_vec   (cor_out_vec)
	);

	// Ready chain of the post stages: a stage takes new data when it is
	// empty or when the stage after it takes its data.
	assign rdy5 = !v_s5 || out_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;

	// A zero vector has no defined angle and is taken as zero.
	assign z_eff = cor_out_vec.zero ? '0 : cor_out_vec.z;

	// Rounded heading, clamped into one turn for out-of-range declinations.
	assign r_raw = RW'(h_s4 >>> FRAC);

	always_comb begin
		if (r_raw[RW-1]) begin
			r_clamp = '0;
		end else if (r_raw > HEAD_MAX) begin
			r_clamp = OW'(HEAD_MAX);
		end else begin
			r_clamp = r_raw[OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy2) begin
				v_s2 <= cor_out_valid;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && cor_out_valid) begin
			h_s2 <= HW'(z_eff) + (HW'(decl_q) <<< FRAC);
		end
		if (rdy3 && v_s2) begin
			h_s3 <= h_s2[HW-1] ? (h_s2 + ANG_360) : h_s2;
		end
		// Wrap above one turn and add the rounding half in the same stage;
		// both sums are formed side by side and the compare selects one.
		if (rdy4 && v_s3) begin
			h_s4 <= (h_s3 > ANG_360) ? (h_s3 - (ANG_360 - ANG_HALF)) : (h_s3 + ANG_HALF);
		end
		if (rdy5 && v_s4) begin
			heading_s5 <= r_clamp;
		end
	end

	assign out_valid = v_s5;
	assign heading   = heading_s5;

endmodule

@@ design/chfm_checker.sv @@
// Port-level checker for the compass heading block, bound to the top level.
`timescale 1ns / 1ps

module chfm_checker
	import chfm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic signed [DW-1:0] cfg_wdata,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic signed [IW-1:0] mag_x,
	input logic signed [IW-1:0] mag_y,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic        [OW-1:0] heading
);

	// A result that is not taken stays shown with the same heading.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading))
		else $error("result dropped or changed while stalled");

	// A shown heading always lies within one turn.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading <= OW'(36000))
		else $error("heading out of range");

	// With the output register free, the ready chain reaches the input.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while the output side can move");

endmodule

bind compass_heading_from_magnetometer chfm_checker u_chfm_checker (.*);
